/* sv/sic_pkg.sv */
// Package for the seismograph IIR cascade: widths, codes, history record
// and the taper table. No dependencies.
`timescale 1ns / 1ps
package sic_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int TAPER_LEN_DEF = 85;
  localparam int SAMPLE_W_DEF  = 24;
  localparam int COEF_FRAC_DEF = 30;

  localparam int VAL_W     = 48;
  localparam int VAL_FRAC  = 16;
  localparam int OUT_W     = 32;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 64;
  localparam int NREGS     = 8;
  localparam int ADDR_W    = 6;
  localparam int TAPER_MAX = 256;
  localparam int TCNT_W    = 8;
  localparam int TAPER_W   = 17;
  localparam int OP_W      = 52;   // widest MAC operand
  localparam int LO_W      = 26;   // low slice of operand per multiply pass
  localparam int ACC_W     = 96;

  localparam logic signed [COEF_W-1:0] GAIN_Q16 = 32'sd2006057;
  localparam logic [63:0] EXP_STEP_Q31 = 64'd2142619587;

  // register indexes
  localparam logic [2:0] REG_SEIS_A     = 3'd0;
  localparam logic [2:0] REG_SEIS_B     = 3'd1;
  localparam logic [2:0] REG_GALV1_A    = 3'd2;
  localparam logic [2:0] REG_GALV1_C_HP = 3'd3;
  localparam logic [2:0] REG_HP_LP      = 3'd4;
  localparam logic [2:0] REG_LP_BC      = 3'd5;
  localparam logic [2:0] REG_GALV2_A    = 3'd6;
  localparam logic [2:0] REG_GALV2_C    = 3'd7;

  typedef enum logic {OP_CLEAR = 1'b0, OP_FILTER = 1'b1} op_e;

  typedef enum logic [2:0] {
    ST_TAPER, ST_SEIS, ST_GALV1, ST_HP, ST_LP, ST_GALV2, ST_GAIN
  } stage_e;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL_LO, S_MUL_HI, S_ROUND} state_e;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t [2:0] si;
    val_t [2:0] so;
    val_t [1:0] g1i;
    val_t [1:0] g1o;
    val_t       hpi;
    val_t       hpo;
    val_t [1:0] lpi;
    val_t [1:0] lpo;
    val_t [1:0] g2i;
    val_t [1:0] g2o;
    logic [TCNT_W-1:0] tcnt;
  } hist_t;

  typedef logic [TAPER_W-1:0] taper_tab_t [TAPER_MAX];

  // taper factors 1 - exp(-n*n/441), unsigned with 16 fractional bits
  function automatic taper_tab_t build_taper();
    taper_tab_t t;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] q;
    e = 64'd1 << 31;
    p = EXP_STEP_Q31;
    q = (p * p + (64'd1 << 30)) >> 31;
    for (int n = 0; n < TAPER_MAX; n++) begin
      t[n] = TAPER_W'(64'd65536 - ((e + 64'd16384) >> 15));
      e = (e * p + (64'd1 << 30)) >> 31;
      p = (p * q + (64'd1 << 30)) >> 31;
    end
    return t;
  endfunction

endpackage

/* sv/sic_if.sv */
// Stream interfaces for the seismograph IIR cascade: sample in, result out.
// Uses sic_pkg for widths.
`timescale 1ns / 1ps
interface sic_in_if #(parameter int SAMPLE_W = sic_pkg::SAMPLE_W_DEF);
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [1:0]                 channel;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, operation, channel, sample, input ready);
  modport sink   (input valid, operation, channel, sample, output ready);
endinterface

interface sic_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sic_pkg::OUT_W-1:0]  filtered;
  logic                              saturated;
  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

/* sv/seismograph_iir_cascade.sv */
// Seismograph simulation filter: taper, five recursive stages, gain.
// Depends on sic_pkg and the stream interfaces in sic_if.sv.
//
// Ready returns the cycle the result is registered. Every product goes
// through one 27x32 multiplier, two passes per term plus an operand load,
// and one rounder per stage. A clear word keeps ready high. Reset zeroes
// the configuration registers, control state, histories and taper
// counters at once; no clearing pass.
`timescale 1ns / 1ps
module seismograph_iir_cascade #(
  parameter int CHANNELS  = sic_pkg::CHANNELS_DEF,
  parameter int TAPER_LEN = sic_pkg::TAPER_LEN_DEF,
  parameter int COEF_FRAC = sic_pkg::COEF_FRAC_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sic_in_if.sink                      in_if,
  sic_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sic_pkg::ADDR_W-1:0]  paddr,
  input  logic [sic_pkg::CFG_W-1:0]   pwdata,
  output logic [sic_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);
  import sic_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam taper_tab_t TAPER = build_taper();

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] cfg_q [NREGS];
  logic [2:0]       reg_idx;
  logic             cfg_wr;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = cfg_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREGS; i++) cfg_q[i] <= '0;
    end else if (cfg_wr) begin
      // the last register is a single word
      cfg_q[reg_idx] <= (reg_idx == REG_GALV2_C) ? {32'b0, pwdata[31:0]} : pwdata;
    end
  end

  function automatic logic signed [COEF_W-1:0] coef(logic [CFG_W-1:0] r, logic half);
    return half ? $signed(r[63:32]) : $signed(r[31:0]);
  endfunction

  // ---------------- control and datapath registers ----------------
  state_e  state_q, state_d;
  stage_e  stage_q, stage_d;
  logic [1:0] term_q, term_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [OP_W-1:0]   opnd_q, opnd_d;
  logic signed [COEF_W-1:0] cf_q, cf_d;
  val_t    val_q, val_d;
  logic    sat_q, sat_d;
  hist_t   cur_q, cur_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  hist_t   hist_q [CHANNELS];
  logic    hist_clr, hist_wr;
  logic    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] filtered_q, filtered_d;
  logic    saturated_q, saturated_d;

  logic in_acc;
  logic [CH_IDX_W+1:0] chan_ext;
  logic ch_ok;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign chan_ext    = (CH_IDX_W+2)'(in_if.channel);
  assign ch_ok       = (32'(in_if.channel) < CHANNELS);

  assign out_if.valid     = out_valid_q;
  assign out_if.filtered  = filtered_q;
  assign out_if.saturated = saturated_q;

  // ---------------- term selection ----------------
  logic signed [OP_W-1:0]   sel_opnd;
  logic signed [COEF_W-1:0] sel_coef;
  logic [1:0]               last_term;

  function automatic logic signed [OP_W-1:0] ext(val_t v);
    return OP_W'($signed(v));
  endfunction

  function automatic logic signed [OP_W-1:0] fir3(val_t x, val_t a, val_t b);
    return ext(x) + (ext(a) <<< 1) + ext(b);
  endfunction

  always_comb begin
    sel_opnd  = '0;
    sel_coef  = '0;
    last_term = 2'd0;
    unique case (stage_q)
      ST_TAPER: begin
        sel_opnd = ext(val_q);
        sel_coef = COEF_W'({1'b0, TAPER[cur_q.tcnt]});
      end
      ST_SEIS: begin
        last_term = 2'd3;
        unique case (term_q)
          2'd0: begin
            sel_opnd = (ext(val_q) - ext(cur_q.si[0]) - ext(cur_q.si[1])
                        + ext(cur_q.si[2])) <<< VAL_FRAC;
            sel_coef = coef(cfg_q[REG_SEIS_A], 1'b0);
          end
          2'd1: begin
            sel_opnd = ext(cur_q.so[0]);
            sel_coef = coef(cfg_q[REG_SEIS_A], 1'b1);
          end
          2'd2: begin
            sel_opnd = ext(cur_q.so[1]);
            sel_coef = coef(cfg_q[REG_SEIS_B], 1'b0);
          end
          default: begin
            sel_opnd = ext(cur_q.so[2]);
            sel_coef = coef(cfg_q[REG_SEIS_B], 1'b1);
          end
        endcase
      end
      ST_GALV1: begin
        last_term = 2'd2;
        unique case (term_q)
          2'd0: begin
            sel_opnd = fir3(val_q, cur_q.g1i[0], cur_q.g1i[1]);
            sel_coef = coef(cfg_q[REG_GALV1_A], 1'b0);
          end
          2'd1: begin
            sel_opnd = ext(cur_q.g1o[0]);
            sel_coef = coef(cfg_q[REG_GALV1_A], 1'b1);
          end
          default: begin
            sel_opnd = ext(cur_q.g1o[1]);
            sel_coef = coef(cfg_q[REG_GALV1_C_HP], 1'b0);
          end
        endcase
      end
      ST_HP: begin
        last_term = 2'd1;
        if (term_q == 2'd0) begin
          sel_opnd = ext(cur_q.hpo);
          sel_coef = coef(cfg_q[REG_GALV1_C_HP], 1'b1);
        end else begin
          sel_opnd = ext(val_q) - ext(cur_q.hpi);
          sel_coef = coef(cfg_q[REG_HP_LP], 1'b0);
        end
      end
      ST_LP: begin
        last_term = 2'd2;
        unique case (term_q)
          2'd0: begin
            sel_opnd = fir3(val_q, cur_q.lpi[0], cur_q.lpi[1]);
            sel_coef = coef(cfg_q[REG_HP_LP], 1'b1);
          end
          2'd1: begin
            sel_opnd = ext(cur_q.lpo[0]);
            sel_coef = coef(cfg_q[REG_LP_BC], 1'b0);
          end
          default: begin
            sel_opnd = ext(cur_q.lpo[1]);
            sel_coef = coef(cfg_q[REG_LP_BC], 1'b1);
          end
        endcase
      end
      ST_GALV2: begin
        last_term = 2'd2;
        unique case (term_q)
          2'd0: begin
            sel_opnd = fir3(val_q, cur_q.g2i[0], cur_q.g2i[1]);
            sel_coef = coef(cfg_q[REG_GALV2_A], 1'b0);
          end
          2'd1: begin
            sel_opnd = ext(cur_q.g2o[0]);
            sel_coef = coef(cfg_q[REG_GALV2_A], 1'b1);
          end
          default: begin
            sel_opnd = ext(cur_q.g2o[1]);
            sel_coef = coef(cfg_q[REG_GALV2_C], 1'b0);
          end
        endcase
      end
      default: begin  // gain
        sel_opnd = ext(val_q);
        sel_coef = GAIN_Q16;
      end
    endcase
  end

  // ---------------- shared multiplier ----------------
  // low pass: unsigned low slice; high pass: signed upper slice, weighted
  logic signed [LO_W:0]              mul_a;
  logic signed [LO_W+COEF_W:0]       mul_p;
  logic signed [ACC_W-1:0]           mul_term;

  assign mul_a    = (state_q == S_MUL_HI) ?
                    $signed({opnd_q[OP_W-1], opnd_q[OP_W-1:LO_W]})
                    : $signed({1'b0, opnd_q[LO_W-1:0]});
  assign mul_p    = mul_a * cf_q;
  assign mul_term = (state_q == S_MUL_HI) ? (ACC_W'(mul_p) <<< LO_W) : ACC_W'(mul_p);

  // ---------------- rounder / saturator ----------------
  logic [5:0]              rnd_sh;
  logic signed [ACC_W-1:0] rnd_sum, rnd_shr, lim_hi, lim_lo;
  logic                    rnd_clip;
  logic signed [VAL_W-1:0] rnd_y;

  always_comb begin
    unique case (stage_q)
      ST_TAPER: rnd_sh = 6'(VAL_FRAC);
      ST_GAIN:  rnd_sh = 6'(VAL_FRAC + 16);
      default:  rnd_sh = 6'(COEF_FRAC);
    endcase
    rnd_sum = acc_q + (ACC_W'(1) <<< (rnd_sh - 6'd1));
    rnd_shr = rnd_sum >>> rnd_sh;
    if (stage_q == ST_GAIN) begin
      lim_hi = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
    end else begin
      lim_hi = (ACC_W'(1) <<< (VAL_W - 1)) - ACC_W'(1);
    end
    lim_lo = -lim_hi - ACC_W'(1);
    rnd_clip = 1'b1;
    if (rnd_shr > lim_hi) begin
      rnd_y = VAL_W'(lim_hi);
    end else if (rnd_shr < lim_lo) begin
      rnd_y = VAL_W'(lim_lo);
    end else begin
      rnd_y    = VAL_W'(rnd_shr);
      rnd_clip = 1'b0;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    term_d      = term_q;
    acc_d       = acc_q;
    opnd_d      = opnd_q;
    cf_d        = cf_q;
    val_d       = val_q;
    sat_d       = sat_q;
    cur_d       = cur_q;
    ch_d        = ch_q;
    hist_clr    = 1'b0;
    hist_wr     = 1'b0;
    filtered_d  = filtered_q;
    saturated_d = saturated_q;
    out_valid_d = out_valid_q && !out_if.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_e'(in_if.operation) == OP_CLEAR) begin
            hist_clr = 1'b1;
          end else if (ch_ok) begin
            ch_d    = chan_ext[CH_IDX_W-1:0];
            cur_d   = hist_q[chan_ext[CH_IDX_W-1:0]];
            val_d   = VAL_W'(in_if.sample);
            sat_d   = 1'b0;
            acc_d   = '0;
            term_d  = 2'd0;
            // skip the taper once a channel is past its window
            stage_d = (32'(hist_q[chan_ext[CH_IDX_W-1:0]].tcnt) < TAPER_LEN) ?
                      ST_TAPER : ST_SEIS;
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        opnd_d  = sel_opnd;
        cf_d    = sel_coef;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        acc_d   = acc_q + mul_term;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        acc_d = acc_q + mul_term;
        if (term_q == last_term) begin
          state_d = S_ROUND;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = S_LOAD;
        end
      end
      S_ROUND: begin
        acc_d   = '0;
        term_d  = 2'd0;
        val_d   = rnd_y;
        state_d = S_LOAD;
        unique case (stage_q)
          ST_TAPER: begin
            cur_d.tcnt = cur_q.tcnt + TCNT_W'(1);
            stage_d    = ST_SEIS;
          end
          ST_SEIS: begin
            cur_d.si = {cur_q.si[1], cur_q.si[0], val_q};
            cur_d.so = {cur_q.so[1], cur_q.so[0], rnd_y};
            stage_d  = ST_GALV1;
          end
          ST_GALV1: begin
            cur_d.g1i = {cur_q.g1i[0], val_q};
            cur_d.g1o = {cur_q.g1o[0], rnd_y};
            stage_d   = ST_HP;
          end
          ST_HP: begin
            cur_d.hpi = val_q;
            cur_d.hpo = rnd_y;
            stage_d   = ST_LP;
          end
          ST_LP: begin
            cur_d.lpi = {cur_q.lpi[0], val_q};
            cur_d.lpo = {cur_q.lpo[0], rnd_y};
            stage_d   = ST_GALV2;
          end
          ST_GALV2: begin
            cur_d.g2i = {cur_q.g2i[0], val_q};
            cur_d.g2o = {cur_q.g2o[0], rnd_y};
            stage_d   = ST_GAIN;
          end
          default: begin
            // hold until the output register is free
            if (!out_valid_q || out_if.ready) begin
              filtered_d  = OUT_W'(rnd_y);
              saturated_d = sat_q || rnd_clip;
              out_valid_d = 1'b1;
              hist_wr     = 1'b1;
              state_d     = S_IDLE;
            end else begin
              acc_d   = acc_q;
              val_d   = val_q;
              state_d = S_ROUND;
            end
          end
        endcase
        if (stage_q != ST_GAIN) sat_d = sat_q || rnd_clip;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    stage_q     <= stage_d;
    term_q      <= term_d;
    acc_q       <= acc_d;
    opnd_q      <= opnd_d;
    cf_q        <= cf_d;
    val_q       <= val_d;
    sat_q       <= sat_d;
    cur_q       <= cur_d;
    ch_q        <= ch_d;
    filtered_q  <= filtered_d;
    saturated_q <= saturated_d;
  end

  // per-channel history, zeroed by reset and by a clear word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) hist_q[c] <= '0;
    end else if (hist_clr) begin
      for (int c = 0; c < CHANNELS; c++) hist_q[c] <= '0;
    end else if (hist_wr) begin
      hist_q[ch_q] <= cur_q;
    end
  end

endmodule

/* sv/sic_checker.sv */
// Port-level checks for the seismograph IIR cascade, bound to its top level.
// Depends on sic_pkg and seismograph_iir_cascade.
`timescale 1ns / 1ps
module sic_checker #(
  parameter int CHANNELS = sic_pkg::CHANNELS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_operation,
  input logic [1:0]                      in_channel,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [sic_pkg::OUT_W-1:0] out_filtered,
  input logic                            out_saturated
);
  import sic_pkg::*;

  // a waiting result word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered)
      && $stable(out_saturated))
    else $error("result word dropped or changed while stalled");

  // a filter word keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_operation && (32'(in_channel) < CHANNELS)
      |=> !in_ready)
    else $error("ready while a sample is in work");

  // a clear word makes no result
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !in_operation |=> !$rose(out_valid))
    else $error("result word after a clear");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result word during reset");

endmodule

bind seismograph_iir_cascade sic_checker #(.CHANNELS(CHANNELS)) u_sic_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_operation (in_if.operation),
  .in_channel   (in_if.channel),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_filtered (out_if.filtered),
  .out_saturated(out_if.saturated)
);

/* dv/tb_top.sv */
// Self-checking bench for seismograph_iir_cascade: scoreboard class with its own
// fixed-point model of taper and five stages. Depends on sic_pkg, sic_if.sv, RTL.
`timescale 1ns / 1ps
module tb_top;
  import sic_pkg::*;

  localparam int NCH       = 4;
  localparam int TLEN      = 85;
  localparam int CFRAC     = 30;
  localparam int DRAIN     = 70;      // a little over the longest sample latency
  localparam int STALL_MAX = 20000;   // cycles without any accepted word

  typedef struct {
    logic signed [OUT_W-1:0] filtered;
    logic                    saturated;
  } result_t;

  typedef logic signed [127:0] wide_t;

  // Scoreboard: mirrors per-channel histories and predicts one word per sample.
  class seis_scoreboard;
    logic [CFG_W-1:0] coef_regs [NREGS];
    longint si [NCH][3], so [NCH][3];
    longint g1i[NCH][2], g1o[NCH][2];
    longint hpi[NCH], hpo[NCH];
    longint lpi[NCH][2], lpo[NCH][2];
    longint g2i[NCH][2], g2o[NCH][2];
    int     taper_pos[NCH];
    longint taper_gain[TLEN];
    result_t expected_words[$];
    int     errors;
    int     samples_seen, clears_seen, sat_seen;

    function new();
      longint unsigned e, p, q;
      e = 64'd1 << 31;
      p = 64'd2142619587;
      q = (p * p + (64'd1 << 30)) >> 31;
      for (int n = 0; n < TLEN; n++) begin
        taper_gain[n] = 65536 - ((e + 16384) >> 15);
        e = (e * p + (64'd1 << 30)) >> 31;
        p = (p * q + (64'd1 << 30)) >> 31;
      end
      foreach (coef_regs[i]) coef_regs[i] = '0;
      errors = 0;
      samples_seen = 0;
      clears_seen = 0;
      sat_seen = 0;
      clear_histories();
    endfunction

    function void clear_histories();
      for (int c = 0; c < NCH; c++) begin
        for (int k = 0; k < 3; k++) begin
          si[c][k] = 0;
          so[c][k] = 0;
        end
        for (int k = 0; k < 2; k++) begin
          g1i[c][k] = 0; g1o[c][k] = 0;
          lpi[c][k] = 0; lpo[c][k] = 0;
          g2i[c][k] = 0; g2o[c][k] = 0;
        end
        hpi[c] = 0;
        hpo[c] = 0;
        taper_pos[c] = 0;
      end
    endfunction

    function void set_reg(int idx, logic [CFG_W-1:0] data);
      coef_regs[idx] = (idx == REG_GALV2_C) ? {32'd0, data[31:0]} : data;
    endfunction

    function longint coef(int idx, int half);
      logic signed [31:0] w;
      w = coef_regs[idx][32*half +: 32];
      return w;
    endfunction

    function wide_t mul(longint a, longint b);
      wide_t wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
    endfunction

    // round half up by sh bits, clip to a signed range of the given width
    function longint round_clip(wide_t acc, int sh, int bits, inout bit sat);
      wide_t r, mx, mn;
      r  = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
      mx = (128'sd1 <<< (bits - 1)) - 1;
      mn = -mx - 1;
      if (r > mx) begin
        sat = 1;
        r = mx;
      end else if (r < mn) begin
        sat = 1;
        r = mn;
      end
      return longint'(r);
    endfunction

    function longint second_order(longint x, inout longint xa0, xa1, ya0, ya1,
                                  input longint c1, c2, c3, inout bit sat);
      wide_t acc;
      longint y;
      acc = mul(x + 2 * xa0 + xa1, c1) + mul(ya0, c2) + mul(ya1, c3);
      y = round_clip(acc, CFRAC, VAL_W, sat);
      xa1 = xa0; xa0 = x;
      ya1 = ya0; ya0 = y;
      return y;
    endfunction

    function void predict_filter(int ch, logic signed [23:0] smp);
      longint x, d, t1, t2, t3, t4, t5, y;
      wide_t acc;
      bit sat;
      result_t r;
      sat = 0;
      x = smp;
      if (taper_pos[ch] < TLEN) begin
        x = (x * taper_gain[taper_pos[ch]] + 32768) >>> 16;
        taper_pos[ch]++;
      end
      d = x - si[ch][0] - si[ch][1] + si[ch][2];
      acc = mul(d * 65536, coef(0, 0)) + mul(so[ch][0], coef(0, 1))
          + mul(so[ch][1], coef(1, 0)) + mul(so[ch][2], coef(1, 1));
      t1 = round_clip(acc, CFRAC, VAL_W, sat);
      so[ch][2] = so[ch][1]; so[ch][1] = so[ch][0]; so[ch][0] = t1;
      si[ch][2] = si[ch][1]; si[ch][1] = si[ch][0]; si[ch][0] = x;
      t2 = second_order(t1, g1i[ch][0], g1i[ch][1], g1o[ch][0], g1o[ch][1],
                        coef(2, 0), coef(2, 1), coef(3, 0), sat);
      acc = mul(hpo[ch], coef(3, 1)) + mul(t2 - hpi[ch], coef(4, 0));
      t3 = round_clip(acc, CFRAC, VAL_W, sat);
      hpo[ch] = t3;
      hpi[ch] = t2;
      t4 = second_order(t3, lpi[ch][0], lpi[ch][1], lpo[ch][0], lpo[ch][1],
                        coef(4, 1), coef(5, 0), coef(5, 1), sat);
      t5 = second_order(t4, g2i[ch][0], g2i[ch][1], g2o[ch][0], g2o[ch][1],
                        coef(6, 0), coef(6, 1), coef(7, 0), sat);
      y = round_clip(mul(t5, 2006057), 32, OUT_W, sat);
      r.filtered  = y[31:0];
      r.saturated = sat;
      expected_words.push_back(r);
    endfunction

    function void note_input(logic op, logic [1:0] ch, logic signed [23:0] smp);
      if (op == OP_CLEAR) begin
        clears_seen++;
        clear_histories();
      end else if (ch < NCH) begin
        samples_seen++;
        predict_filter(ch, smp);
      end
    endfunction

    function void check_result(logic signed [31:0] f, logic s);
      result_t e;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: filtered %0d saturated %0b", f, s);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (s) sat_seen++;
      if (f !== e.filtered) begin
        $error("filtered: expected %0d actual %0d", e.filtered, f);
        errors++;
      end
      if (s !== e.saturated) begin
        $error("saturated: expected %0b actual %0b", e.saturated, s);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  sic_in_if  in_if ();
  sic_out_if out_if ();

  seismograph_iir_cascade u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  seis_scoreboard sb = new();

  // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both at a light rate
  int idle_mode = 0;
  int stall_count = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Drop ready on the result side at the rate the current mode asks.
  always @(posedge clk_i) begin
    case (idle_mode)
      2: out_if.ready <= ($urandom_range(99) >= 83);
      3: out_if.ready <= ($urandom_range(99) >= 11);
      default: out_if.ready <= 1'b1;
    endcase
  end

  // Monitors: every accepted word on either side goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.operation, in_if.channel, in_if.sample);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.filtered, out_if.saturated);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_MAX) begin
        $display("timeout: no word moved for %0d cycles", STALL_MAX);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Setup phase, then access phase; the register takes the value at the access edge.
  task automatic apb_write(int idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Hold one word on the sample side until it is taken; idle first if asked.
  task automatic send_word(logic op, logic [1:0] ch, logic [23:0] smp);
    int rate;
    rate = (idle_mode == 1) ? 83 : (idle_mode == 3) ? 11 : 0;
    if (rate > 0 && $urandom_range(99) < rate) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < rate) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.channel   <= ch;
    in_if.sample    <= smp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drop valid at the accepting edge, then wait out every pending result.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coef(int kind);
    case (kind)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(1 << 29)) - (1 << 28);   // tame
    endcase
  endfunction

  // Load all eight registers from one coefficient flavor (or mixed at random).
  task automatic load_coefs(int kind);
    logic [CFG_W-1:0] v;
    for (int i = 0; i < NREGS; i++) begin
      v = {pick_coef(kind < 4 ? kind : $urandom_range(3)),
           pick_coef(kind < 4 ? kind : $urandom_range(3))};
      apb_write(i, v);
    end
  endtask

  logic [23:0] edge_samples [4] = '{24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 24'hFF_FFFF};

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_if.valid  <= 1'b0;
    in_if.operation <= OP_FILTER;
    in_if.channel   <= '0;
    in_if.sample    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset coefficients with extremes on every channel, tame ones
    // with a clear to restart the taper, then full-scale max and min passes.
    for (int c = 0; c < NCH; c++) send_word(OP_FILTER, c[1:0], edge_samples[c]);
    drain();
    load_coefs(3);
    for (int k = 0; k < 8; k++) send_word(OP_FILTER, k[1:0], edge_samples[k % 4]);
    send_word(OP_CLEAR, 2'd0, 24'h0);
    for (int k = 0; k < 4; k++) send_word(OP_FILTER, 2'd1, edge_samples[k]);
    drain();
    load_coefs(0);
    for (int k = 0; k < 4; k++) send_word(OP_FILTER, k[1:0], edge_samples[k]);
    drain();
    load_coefs(1);
    for (int k = 0; k < 4; k++) send_word(OP_FILTER, k[1:0], edge_samples[3 - k]);
    drain();

    // Random phases: rotate idle modes and coefficient flavors; mostly samples
    // with an occasional clear so the taper window is revisited.
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      load_coefs(ph == 7 ? 4 : (ph < 4 ? 3 : ph - 4));
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(99) < 3)
          send_word(OP_CLEAR, 2'($urandom), 24'($urandom));
        else
          send_word(OP_FILTER, 2'($urandom), 24'($urandom));
      end
      drain();
    end
    idle_mode = 0;

    $display("covered %0d samples and %0d clears on %0d channels, %0d clipped words",
             sb.samples_seen, sb.clears_seen, NCH, sb.sat_seen);
    $display("coefficient sets: reset, tame, full-scale max/min, random; four idle modes");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
